// ===== sv/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg: shared definitions for the epoch seconds to calendar unit
// Widths, reciprocal division constants, datapath opcodes,
// controller/datapath structs and the Gregorian helper functions.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Field widths
    localparam int SEC_W  = 32;              // input seconds count
    localparam int SUM_W  = SEC_W + 1;       // seconds plus zone offset
    localparam int DAY_W  = 16;              // whole days, up to year 2106
    localparam int ZONE_W = 5;

    // Division by constants as q = (x * RECIP) >> SHIFT, exact over each
    // operand's range. Powers of two are shifted off first.
    // Days: (t >> 7) / 675, since 86400 = 675 * 128; operand below 2^26
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam int          DAY_SHIFT  = 35;
    localparam logic [9:0]  DAY_ODD    = 10'd675;
    // Hour: (sod >> 4) / 225, since 3600 = 225 * 16; operand below 5400
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam int          HOUR_SHIFT = 21;
    localparam logic [7:0]  HOUR_ODD   = 8'd225;
    // Minute: (rest >> 2) / 15, since 60 = 15 * 4; operand below 900
    localparam logic [10:0] MIN_RECIP  = 11'd1093;
    localparam int          MIN_SHIFT  = 14;
    localparam logic [3:0]  MIN_ODD    = 4'd15;
    // Weeks: (days + 4) / 7; operand below 2^16
    localparam logic [16:0] WEEK_RECIP = 17'd74899;
    localparam int          WEEK_SHIFT = 19;
    // Four-year blocks: days / 1461; operand below 49713
    localparam logic [16:0] QUAD_RECIP = 17'd91868;
    localparam int          QUAD_SHIFT = 27;
    localparam logic [10:0] QUAD_DAYS  = 11'd1461;

    // Calendar constants
    localparam logic [16:0]      SECS_PER_HOUR = 17'd3600;
    localparam logic [7:0]       EPOCH_YEARS   = 8'd70;    // 1970 - 1900
    localparam logic [7:0]       NOLEAP_1900   = 8'd0;     // century, not leap
    localparam logic [7:0]       NOLEAP_2100   = 8'd200;   // century, not leap
    // First day of 2102: the block 2098..2101 is one day short (2100 not leap),
    // so days from here on are bumped by one before the four-year division.
    localparam logic [DAY_W-1:0] DAY_2102      = 16'd48212;
    localparam logic [3:0]       MON_FEB       = 4'd1;
    localparam logic [3:0]       MON_DEC       = 4'd11;
    localparam logic [2:0]       WEEK_DAYS     = 3'd7;
    localparam logic [2:0]       EPOCH_WDAY    = 3'd4;     // 1970-01-01 Thursday

    // Datapath opcodes
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_DAYS   = 4'd2;
    localparam logic [3:0] OP_SPLIT  = 4'd3;
    localparam logic [3:0] OP_HOUR   = 4'd4;
    localparam logic [3:0] OP_MINREM = 4'd5;
    localparam logic [3:0] OP_MIN    = 4'd6;
    localparam logic [3:0] OP_SEC    = 4'd7;
    localparam logic [3:0] OP_YEAR   = 4'd8;
    localparam logic [3:0] OP_MONTH  = 4'd9;

    typedef struct packed {
        logic [3:0] op;
        logic       out_load;
    } esc_cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } esc_status_t;

    // Leap test on years since 1900 (range 0..255)
    function automatic logic is_leap(input logic [7:0] ys);
        return (ys[1:0] == 2'b00) && (ys != NOLEAP_1900) && (ys != NOLEAP_2100);
    endfunction

    // Month length in days
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/esc_ctrl.sv =====
// ----------------------------------------------------------------------------
// esc_ctrl: conversion sequencer
// Steps the datapath through the day, hour, minute and second splits,
// the year and month walks, and hands the result to the output register.
// ----------------------------------------------------------------------------
module esc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  esc_pkg::esc_status_t status,
    output esc_pkg::esc_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DAYS   = 4'd1;
    localparam logic [3:0] S_SPLIT  = 4'd2;
    localparam logic [3:0] S_HOUR   = 4'd3;
    localparam logic [3:0] S_MINREM = 4'd4;
    localparam logic [3:0] S_MIN    = 4'd5;
    localparam logic [3:0] S_SEC    = 4'd6;
    localparam logic [3:0] S_YEAR   = 4'd7;
    localparam logic [3:0] S_MONTH  = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and command
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = esc_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = esc_pkg::OP_LOAD;
                    state_next = S_DAYS;
                end
            end
            S_DAYS:
            begin
                cmd.op     = esc_pkg::OP_DAYS;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.op     = esc_pkg::OP_SPLIT;
                state_next = S_HOUR;
            end
            S_HOUR:
            begin
                cmd.op     = esc_pkg::OP_HOUR;
                state_next = S_MINREM;
            end
            S_MINREM:
            begin
                cmd.op     = esc_pkg::OP_MINREM;
                state_next = S_MIN;
            end
            S_MIN:
            begin
                cmd.op     = esc_pkg::OP_MIN;
                state_next = S_SEC;
            end
            S_SEC:
            begin
                cmd.op     = esc_pkg::OP_SEC;
                state_next = S_YEAR;
            end
            S_YEAR:
            begin
                cmd.op = esc_pkg::OP_YEAR;
                if (status.year_done)
                    state_next = S_MONTH;
            end
            S_MONTH:
            begin
                cmd.op = esc_pkg::OP_MONTH;
                if (status.month_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/esc_dp.sv =====
// ----------------------------------------------------------------------------
// esc_dp: conversion datapath
// Zone register, reciprocal-multiply splits, weekday residue, year and month
// walk, and the output register.
// ----------------------------------------------------------------------------
module esc_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [esc_pkg::ZONE_W-1:0]  zone_offset_hours,
    input  logic [esc_pkg::SEC_W-1:0]   epoch_seconds,
    input  esc_pkg::esc_cmd_t           cmd,
    output esc_pkg::esc_status_t        status,
    output logic [4:0]                  hour,
    output logic [5:0]                  minute,
    output logic [5:0]                  second,
    output logic [2:0]                  weekday,
    output logic [7:0]                  years_since_1900,
    output logic [8:0]                  day_of_year,
    output logic [3:0]                  month_index,
    output logic [4:0]                  day_of_month
);

    localparam int SW = esc_pkg::SUM_W;
    localparam int DW = esc_pkg::DAY_W;

    logic [esc_pkg::ZONE_W-1:0] zone_reg, zone_next;

    // Working registers
    logic [SW-1:0] t_reg, t_next;
    logic [DW-1:0] eday_reg, eday_next;
    logic [16:0]   sod_reg, sod_next;
    logic [11:0]   rsec_reg, rsec_next;
    logic [12:0]   qwk_reg, qwk_next;
    logic [5:0]    quad_reg, quad_next;
    logic [2:0]    wk_reg, wk_next;
    logic [DW-1:0] days_reg, days_next;
    logic [8:0]    yday_reg, yday_next;
    logic [7:0]    year_reg, year_next;
    logic [3:0]    mon_reg, mon_next;
    logic [4:0]    hour_reg, hour_next;
    logic [5:0]    min_reg, min_next;
    logic [5:0]    sec_reg, sec_next;

    // Output register
    logic [4:0] o_hour_reg;
    logic [5:0] o_min_reg;
    logic [5:0] o_sec_reg;
    logic [2:0] o_wday_reg;
    logic [7:0] o_year_reg;
    logic [8:0] o_yday_reg;
    logic [3:0] o_mon_reg;
    logic [4:0] o_mday_reg;

    logic [16:0]   zone_secs;
    logic [SW-1:0] t_sum;
    logic [51:0]   day_prod;
    logic [25:0]   day_back;
    logic [25:0]   day_rem;
    logic [DW-1:0] adj_days;
    logic [DW-1:0] wk_in;
    logic [32:0]   week_prod;
    logic [DW-1:0] wk_back;
    logic [DW-1:0] wk_rem;
    logic [32:0]   quad_prod;
    logic [DW-1:0] quad_back;
    logic [26:0]   hour_prod;
    logic [12:0]   hour_back;
    logic [12:0]   hour_rem;
    logic [20:0]   min_prod;
    logic [9:0]    min_back;
    logic [9:0]    min_rem;
    logic          leap;
    logic [8:0]    ylen;
    logic          year_ge;
    logic [4:0]    mlen;
    logic          mon_ge;

    // Offset write, reduced to 0..23
    assign zone_next = (zone_offset_hours >= 5'd24) ? zone_offset_hours - 5'd24
                                                    : zone_offset_hours;

    // Local seconds count
    assign zone_secs = 17'(zone_reg) * esc_pkg::SECS_PER_HOUR;
    assign t_sum     = {1'b0, epoch_seconds} + SW'(zone_secs);

    // Whole days and second of day
    assign day_prod = 52'(t_reg[SW-1:7]) * 52'(esc_pkg::DAY_RECIP);
    assign day_back = 26'(eday_reg) * 26'(esc_pkg::DAY_ODD);
    assign day_rem  = t_reg[SW-1:7] - day_back;

    // Weekday residue of days + 4
    assign wk_in     = eday_reg + DW'(esc_pkg::EPOCH_WDAY);
    assign week_prod = 33'(wk_in) * 33'(esc_pkg::WEEK_RECIP);
    assign wk_back   = DW'(qwk_reg) * DW'(esc_pkg::WEEK_DAYS);
    assign wk_rem    = wk_in - wk_back;

    // Skip the missing leap day of 2100 before the four-year division
    assign adj_days  = (eday_reg >= esc_pkg::DAY_2102) ? eday_reg + DW'(1) : eday_reg;
    assign quad_prod = 33'(adj_days) * 33'(esc_pkg::QUAD_RECIP);
    assign quad_back = DW'(quad_reg) * DW'(esc_pkg::QUAD_DAYS);

    // Hour, minute and second of the day
    assign hour_prod = 27'(sod_reg[16:4]) * 27'(esc_pkg::HOUR_RECIP);
    assign hour_back = 13'(hour_reg) * 13'(esc_pkg::HOUR_ODD);
    assign hour_rem  = sod_reg[16:4] - hour_back;
    assign min_prod  = 21'(rsec_reg[11:2]) * 21'(esc_pkg::MIN_RECIP);
    assign min_back  = 10'(min_reg) * 10'(esc_pkg::MIN_ODD);
    assign min_rem   = rsec_reg[11:2] - min_back;

    // Year and month lengths
    assign leap    = esc_pkg::is_leap(year_reg);
    assign ylen    = leap ? 9'd366 : 9'd365;
    assign year_ge = (days_reg >= DW'(ylen));
    assign mlen    = esc_pkg::month_len(mon_reg, leap);
    assign mon_ge  = (days_reg >= DW'(mlen));

    assign status.year_done  = !year_ge;
    assign status.month_done = (mon_reg == esc_pkg::MON_DEC) || !mon_ge;

    // Datapath operations
    always_comb
    begin
        t_next    = t_reg;
        eday_next = eday_reg;
        sod_next  = sod_reg;
        rsec_next = rsec_reg;
        qwk_next  = qwk_reg;
        quad_next = quad_reg;
        wk_next   = wk_reg;
        days_next = days_reg;
        yday_next = yday_reg;
        year_next = year_reg;
        mon_next  = mon_reg;
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;
        case (cmd.op)
            esc_pkg::OP_LOAD:
            begin
                t_next = t_sum;
            end
            esc_pkg::OP_DAYS:
            begin
                eday_next = day_prod[esc_pkg::DAY_SHIFT +: DW];
            end
            esc_pkg::OP_SPLIT:
            begin
                sod_next  = {day_rem[9:0], t_reg[6:0]};
                qwk_next  = week_prod[esc_pkg::WEEK_SHIFT +: 13];
                quad_next = quad_prod[esc_pkg::QUAD_SHIFT +: 6];
            end
            esc_pkg::OP_HOUR:
            begin
                hour_next = hour_prod[esc_pkg::HOUR_SHIFT +: 5];
                wk_next   = wk_rem[2:0];
                days_next = adj_days - quad_back;
                year_next = esc_pkg::EPOCH_YEARS + {quad_reg, 2'b00};
                mon_next  = '0;
            end
            esc_pkg::OP_MINREM:
            begin
                // seconds within the hour
                rsec_next = {hour_rem[7:0], sod_reg[3:0]};
            end
            esc_pkg::OP_MIN:
            begin
                min_next = min_prod[esc_pkg::MIN_SHIFT +: 6];
            end
            esc_pkg::OP_SEC:
            begin
                sec_next = {min_rem[3:0], rsec_reg[1:0]};
            end
            esc_pkg::OP_YEAR:
            begin
                if (year_ge)
                begin
                    days_next = days_reg - DW'(ylen);
                    year_next = year_reg + 8'd1;
                end
                else
                begin
                    yday_next = days_reg[8:0];
                end
            end
            esc_pkg::OP_MONTH:
            begin
                if (!status.month_done)
                begin
                    days_next = days_reg - DW'(mlen);
                    mon_next  = mon_reg + 4'd1;
                end
            end
            default:
            begin
                t_next = t_reg;
            end
        endcase
    end

    // Working and output registers
    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        eday_reg <= eday_next;
        sod_reg  <= sod_next;
        rsec_reg <= rsec_next;
        qwk_reg  <= qwk_next;
        quad_reg <= quad_next;
        wk_reg   <= wk_next;
        days_reg <= days_next;
        yday_reg <= yday_next;
        year_reg <= year_next;
        mon_reg  <= mon_next;
        hour_reg <= hour_next;
        min_reg  <= min_next;
        sec_reg  <= sec_next;
        if (cmd.out_load)
        begin
            o_hour_reg <= hour_reg;
            o_min_reg  <= min_reg;
            o_sec_reg  <= sec_reg;
            o_wday_reg <= wk_reg;
            o_year_reg <= year_reg;
            o_yday_reg <= yday_reg;
            o_mon_reg  <= mon_reg;
            o_mday_reg <= days_reg[4:0] + 5'd1;
        end
    end

    // Zone offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zone_reg <= 5'd8;
        else if (cfg_we)
            zone_reg <= zone_next;
    end

    assign hour             = o_hour_reg;
    assign minute           = o_min_reg;
    assign second           = o_sec_reg;
    assign weekday          = o_wday_reg;
    assign years_since_1900 = o_year_reg;
    assign day_of_year      = o_yday_reg;
    assign month_index      = o_mon_reg;
    assign day_of_month     = o_mday_reg;

endmodule

// ===== sv/epoch_seconds_to_calendar_unit.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit: seconds since 1970 to local calendar time
// Top level: sequencer, datapath and the configuration port.
// ----------------------------------------------------------------------------
// One item at a time. A seconds count is taken on a beat of the input channel,
// the zone offset is added in the accept cycle, and the result then passes
// through the reciprocal multiplies that split the count into days, second of
// day, weekday, four-year block, hour, minute and second, the year walk inside
// the block, the month walk, and the load into the output register, which
// waits while a previous result is still held under out_stall. in_stall is
// high from the accept until the result has entered the output register, and
// the next beat can be taken as soon as it drops, even while the result still
// waits under out_stall. cfg_ready is always high; write the zone offset only
// while the unit is idle. Offsets above 23 are reduced by 24.
module epoch_seconds_to_calendar_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [esc_pkg::ZONE_W-1:0]  zone_offset_hours,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [esc_pkg::SEC_W-1:0]   epoch_seconds,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [4:0]                  hour,
    output logic [5:0]                  minute,
    output logic [5:0]                  second,
    output logic [2:0]                  weekday,
    output logic [7:0]                  years_since_1900,
    output logic [8:0]                  day_of_year,
    output logic [3:0]                  month_index,
    output logic [4:0]                  day_of_month
);

    esc_pkg::esc_cmd_t    cmd;
    esc_pkg::esc_status_t status;
    logic                 cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    // Sequencer
    esc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    esc_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .zone_offset_hours (zone_offset_hours),
        .epoch_seconds     (epoch_seconds),
        .cmd               (cmd),
        .status            (status),
        .hour              (hour),
        .minute            (minute),
        .second            (second),
        .weekday           (weekday),
        .years_since_1900  (years_since_1900),
        .day_of_year       (day_of_year),
        .month_index       (month_index),
        .day_of_month      (day_of_month)
    );

endmodule

// ===== sv/esc_checker.sv =====
// ----------------------------------------------------------------------------
// esc_checker: port-level checks for the calendar unit
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module esc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second,
    input logic [2:0]  weekday,
    input logic [7:0]  years_since_1900,
    input logic [8:0]  day_of_year,
    input logic [3:0]  month_index,
    input logic [4:0]  day_of_month
);

    // A held result beat keeps its valid and payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hour) && $stable(minute)
            && $stable(second) && $stable(weekday) && $stable(years_since_1900)
            && $stable(day_of_year) && $stable(month_index) && $stable(day_of_month))
        else $error("result beat changed while stalled");

    // One item at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // Time and date fields in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour < 5'd24 && minute < 6'd60 && second < 6'd60
            && weekday < 3'd7 && month_index < 4'd12 && day_of_month != 5'd0
            && day_of_year < 9'd366 && years_since_1900 >= 8'd70
            && years_since_1900 <= 8'd206)
        else $error("result field out of range");

    // January: day of year follows day of month
    a_january: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && month_index == 4'd0 |-> day_of_year == 9'(day_of_month) - 9'd1)
        else $error("day of year disagrees with January date");

endmodule

bind epoch_seconds_to_calendar_unit esc_checker u_esc_checker (.*);
